// File: hdl/pspm_pkg.sv
// Shared types and constants for the pedal sensor plausibility monitor.
// Holds the item structs, operation and channel codes, and register defaults.
// No dependencies.
package pspm_pkg;

	localparam int PEDAL_W    = 12;
	localparam int THROTTLE_W = 16;
	localparam int TIME_W     = 32;
	localparam int TPS_SUM_W  = 17;
	localparam int APPS_SUM_W = 13;
	localparam int DELAY_W    = 16;
	localparam int CFG_DATA_W = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int NUM_CHECKS = 4;
	localparam int NUM_CH     = 5;

	// Operation codes of an input item.
	localparam logic [1:0] OP_EVAL     = 2'd0;
	localparam logic [1:0] OP_THROTTLE = 2'd1;
	localparam logic [1:0] OP_MODE     = 2'd2;

	// Result channels.
	localparam logic [2:0] CH_TPS   = 3'd0;
	localparam logic [2:0] CH_APPS  = 3'd1;
	localparam logic [2:0] CH_TRACK = 3'd2;
	localparam logic [2:0] CH_MODE  = 3'd3;
	localparam logic [2:0] CH_TELEM = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TPS_SUM_LOW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TPS_SUM_HIGH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_APPS_SUM_LOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_APPS_SUM_HIGH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SUM_DELAY     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TRACK_DELAY   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MODE_DELAY    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TRACK_ENABLE  = 3'd7;

	// Register reset values.
	localparam logic [TPS_SUM_W-1:0]  TPS_SUM_LOW_RST   = 17'd950;
	localparam logic [TPS_SUM_W-1:0]  TPS_SUM_HIGH_RST  = 17'd1050;
	localparam logic [APPS_SUM_W-1:0] APPS_SUM_LOW_RST  = 13'd3895;
	localparam logic [APPS_SUM_W-1:0] APPS_SUM_HIGH_RST = 13'd4305;
	localparam logic [DELAY_W-1:0]    SUM_DELAY_RST     = 16'd150;
	localparam logic [DELAY_W-1:0]    TRACK_DELAY_RST   = 16'd750;
	localparam logic [DELAY_W-1:0]    MODE_DELAY_RST    = 16'd1500;

	// Fixed thresholds.
	localparam logic [THROTTLE_W-1:0] IDLE_LOW     = 16'd66;
	localparam logic [THROTTLE_W-1:0] IDLE_HIGH    = 16'd74;
	localparam logic [THROTTLE_W-1:0] TRACK_TOL    = 16'd50;
	localparam logic [TIME_W-1:0]     TELEM_GAP    = 32'd8;
	localparam logic [7:0]            MODE_ARM_VAL = 8'd1;

	typedef struct packed {
		logic [1:0]            op;
		logic [TIME_W-1:0]     now_ms;
		logic [PEDAL_W-1:0]    pedal_a;
		logic [PEDAL_W-1:0]    pedal_b;
		logic [THROTTLE_W-1:0] throttle_a;
		logic [THROTTLE_W-1:0] throttle_b;
		logic [THROTTLE_W-1:0] throttle_target;
		logic [7:0]            mode_value;
	} pspm_in_t;

	typedef struct packed {
		logic [2:0]         channel;
		logic               fault;
		logic [PEDAL_W-1:0] sample_a;
		logic [PEDAL_W-1:0] sample_b;
		logic               last;
	} pspm_out_t;

endpackage

// File: hdl/pedal_sensor_plausibility_monitor.sv
// An evaluate item passes the input register and then the result register before the
// first result of its pass is valid; it waits in the input register while results drain.
// Throttle and mode frames produce no results and do not wait for them; an evaluate pass
// yields k results (0 to 5), one result delivered per cycle by the output register
// while out_ready is high.
// Reset (arst_n low, asynchronous) clears all check state and loads the
// register defaults; no clearing pass is needed.
module pedal_sensor_plausibility_monitor
	import pspm_pkg::*;
#(
	parameter int REPEAT_LIMIT = 3,
	parameter int SAMPLE_BITS  = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pspm_in_t             in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pspm_out_t            out_item,
	input  logic                 write_enable,
	input  logic [CFG_IDX_W-1:0] register_index,
	input  logic [CFG_DATA_W-1:0] write_data
);

	localparam int CNT_W = $clog2(REPEAT_LIMIT + 1);
	localparam logic [CNT_W-1:0] LIMIT = CNT_W'(REPEAT_LIMIT);
	localparam int SMW = (SAMPLE_BITS < PEDAL_W) ? SAMPLE_BITS : PEDAL_W;
	localparam logic [PEDAL_W-1:0] SAMPLE_MASK = PEDAL_W'((64'd1 << SMW) - 64'd1);

	// Configuration registers.
	logic [TPS_SUM_W-1:0]  tps_sum_low_q, tps_sum_high_q;
	logic [APPS_SUM_W-1:0] apps_sum_low_q, apps_sum_high_q;
	logic [DELAY_W-1:0]    sum_delay_q, track_delay_q, mode_delay_q;
	logic                  track_enable_q;

	// Check state.
	logic [THROTTLE_W-1:0] throttle_a_q, throttle_b_q, throttle_target_q;
	logic                  throttle_seen_q;
	logic [7:0]            mode_request_q;
	logic [TIME_W-1:0]     start_q [NUM_CHECKS];
	logic [TIME_W-1:0]     start_d [NUM_CHECKS];
	logic [NUM_CHECKS-1:0] pend_q, pend_d, rep_q, rep_d;
	logic [CNT_W-1:0]      raise_q [NUM_CHECKS];
	logic [CNT_W-1:0]      raise_d [NUM_CHECKS];
	logic [CNT_W-1:0]      clr_q [NUM_CHECKS];
	logic [CNT_W-1:0]      clr_d [NUM_CHECKS];
	logic [TIME_W-1:0]     recover_q, recover_d;
	logic [TIME_W-1:0]     telem_q;

	// Input stage and result stage.
	logic                  valid_s1;
	pspm_in_t              item_s1;
	logic [NUM_CH-1:0]     mask_s2;
	logic [NUM_CHECKS-1:0] fault_s2;
	logic [PEDAL_W-1:0]    sample_a_s2, sample_b_s2;

	logic                  is_eval, go, go_eval, drain;
	logic [NUM_CH-1:0]     mask_after, new_mask;
	logic [NUM_CHECKS-1:0] new_fault, bad, good;
	logic [DELAY_W-1:0]    delay [NUM_CHECKS];
	logic                  mode_good, mode_clear, telem_due;
	logic [PEDAL_W-1:0]    pa, pb;
	logic [TPS_SUM_W-1:0]  tps_sum;
	logic [APPS_SUM_W-1:0] apps_sum;
	logic [THROTTLE_W-1:0] track_diff;
	logic [TIME_W-1:0]     now;
	logic                  mode_armed;
	logic [2:0]            sel;

	// Handshake control. Frames never produce results, so they pass while
	// earlier results still drain; an evaluate pass waits for a free result stage.
	assign drain      = out_valid & out_ready;
	assign mask_after = drain ? (mask_s2 & (mask_s2 - 1'b1)) : mask_s2;
	assign is_eval    = (item_s1.op == OP_EVAL);
	assign go         = valid_s1 & (!is_eval | (mask_after == '0));
	assign go_eval    = go & is_eval;
	assign in_ready   = !valid_s1 | go;

	// Check conditions.
	assign now        = item_s1.now_ms;
	assign pa         = item_s1.pedal_a & SAMPLE_MASK;
	assign pb         = item_s1.pedal_b & SAMPLE_MASK;
	assign tps_sum    = {1'b0, throttle_a_q} + {1'b0, throttle_b_q};
	assign apps_sum   = {1'b0, pa} + {1'b0, pb};
	assign track_diff = (throttle_target_q >= throttle_a_q) ?
		(throttle_target_q - throttle_a_q) : (throttle_a_q - throttle_target_q);
	assign mode_armed = (mode_request_q == MODE_ARM_VAL);

	always_comb begin
		bad[0]  = throttle_seen_q & ((tps_sum > tps_sum_high_q) | (tps_sum < tps_sum_low_q));
		good[0] = throttle_seen_q & (tps_sum < tps_sum_high_q) & (tps_sum > tps_sum_low_q);
		bad[1]  = (apps_sum > apps_sum_high_q) | (apps_sum < apps_sum_low_q);
		good[1] = (apps_sum < apps_sum_high_q) & (apps_sum > apps_sum_low_q);
		bad[2]  = track_enable_q & (track_diff > TRACK_TOL);
		good[2] = track_enable_q & (track_diff < TRACK_TOL);
		bad[3]  = mode_armed & ((throttle_a_q < IDLE_LOW) | (throttle_a_q > IDLE_HIGH));
		// The idle check has its own recovery path below.
		good[3] = 1'b0;
		delay[0] = sum_delay_q;
		delay[1] = sum_delay_q;
		delay[2] = track_delay_q;
		delay[3] = mode_delay_q;
	end

	assign mode_good = mode_armed & (throttle_a_q > IDLE_LOW) & (throttle_a_q < IDLE_HIGH);
	assign telem_due = ((now - telem_q) > TELEM_GAP);

	always_comb begin
		pend_d     = pend_q;
		rep_d      = rep_q;
		start_d    = start_q;
		raise_d    = raise_q;
		clr_d      = clr_q;
		recover_d  = recover_q;
		new_mask   = '0;
		new_fault  = '0;
		mode_clear = 1'b0;
		for (int c = 0; c < NUM_CHECKS; c++) begin
			if (bad[c]) begin
				if (!pend_q[c]) begin
					start_d[c] = now;
					pend_d[c]  = 1'b1;
					clr_d[c]   = '0;
				end
				// A freshly armed timer has zero elapsed time and cannot raise yet.
				if (pend_q[c] && ((now - start_q[c]) > TIME_W'(delay[c])) &&
					(raise_q[c] < LIMIT)) begin
					rep_d[c]     = 1'b1;
					raise_d[c]   = CNT_W'(raise_q[c] + 1'b1);
					new_mask[c]  = 1'b1;
					new_fault[c] = 1'b1;
				end
			end else if (good[c] && pend_q[c]) begin
				pend_d[c]  = 1'b0;
				raise_d[c] = '0;
				if (rep_q[c] && (clr_q[c] < LIMIT)) begin
					rep_d[c]    = 1'b0;
					clr_d[c]    = CNT_W'(clr_q[c] + 1'b1);
					new_mask[c] = 1'b1;
				end
			end
		end
		// Idle recovery may clear even without an earlier raise.
		if (mode_good) begin
			if (pend_q[3]) begin
				pend_d[3]  = 1'b0;
				recover_d  = now;
				raise_d[3] = '0;
			end
			if (!pend_q[3] && ((now - recover_q) > TIME_W'(mode_delay_q)) &&
				(clr_q[3] < LIMIT)) begin
				rep_d[3]    = 1'b0;
				clr_d[3]    = CNT_W'(clr_q[3] + 1'b1);
				mode_clear  = 1'b1;
				new_mask[3] = 1'b1;
			end
		end
		new_mask[CH_TELEM] = telem_due;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_sum_low_q   <= TPS_SUM_LOW_RST;
			tps_sum_high_q  <= TPS_SUM_HIGH_RST;
			apps_sum_low_q  <= APPS_SUM_LOW_RST;
			apps_sum_high_q <= APPS_SUM_HIGH_RST;
			sum_delay_q     <= SUM_DELAY_RST;
			track_delay_q   <= TRACK_DELAY_RST;
			mode_delay_q    <= MODE_DELAY_RST;
			track_enable_q  <= 1'b0;
		end else if (write_enable) begin
			case (register_index)
				REG_TPS_SUM_LOW:   tps_sum_low_q   <= write_data;
				REG_TPS_SUM_HIGH:  tps_sum_high_q  <= write_data;
				REG_APPS_SUM_LOW:  apps_sum_low_q  <= write_data[APPS_SUM_W-1:0];
				REG_APPS_SUM_HIGH: apps_sum_high_q <= write_data[APPS_SUM_W-1:0];
				REG_SUM_DELAY:     sum_delay_q     <= write_data[DELAY_W-1:0];
				REG_TRACK_DELAY:   track_delay_q   <= write_data[DELAY_W-1:0];
				REG_MODE_DELAY:    mode_delay_q    <= write_data[DELAY_W-1:0];
				REG_TRACK_ENABLE:  track_enable_q  <= write_data[0];
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	// Check state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			throttle_a_q      <= '0;
			throttle_b_q      <= '0;
			throttle_target_q <= '0;
			throttle_seen_q   <= 1'b0;
			mode_request_q    <= '0;
			pend_q            <= '0;
			rep_q             <= '0;
			recover_q         <= '0;
			telem_q           <= '0;
			for (int c = 0; c < NUM_CHECKS; c++) begin
				start_q[c] <= '0;
				raise_q[c] <= '0;
				clr_q[c]   <= '0;
			end
		end else if (go) begin
			if (item_s1.op == OP_THROTTLE) begin
				throttle_a_q      <= item_s1.throttle_a;
				throttle_b_q      <= item_s1.throttle_b;
				throttle_target_q <= item_s1.throttle_target;
				throttle_seen_q   <= 1'b1;
			end else if (item_s1.op == OP_MODE) begin
				mode_request_q <= item_s1.mode_value;
			end else if (is_eval) begin
				pend_q    <= pend_d;
				rep_q     <= rep_d;
				recover_q <= recover_d;
				start_q   <= start_d;
				raise_q   <= raise_d;
				clr_q     <= clr_d;
				if (mode_clear) begin
					mode_request_q <= '0;
				end
				if (telem_due) begin
					telem_q <= now;
				end
			end
		end
	end

	// Result register: one bit per pending result, drained lowest channel first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s2 <= '0;
		end else begin
			mask_s2 <= go_eval ? new_mask : mask_after;
		end
	end

	always_ff @(posedge clk) begin
		if (go_eval) begin
			fault_s2    <= new_fault;
			sample_a_s2 <= pa;
			sample_b_s2 <= pb;
		end
	end

	always_comb begin
		sel = CH_TELEM;
		for (int c = NUM_CH - 1; c >= 0; c--) begin
			if (mask_s2[c]) begin
				sel = 3'(c);
			end
		end
	end

	assign out_valid         = (mask_s2 != '0);
	assign out_item.channel  = sel;
	assign out_item.fault    = (sel == CH_TELEM) ? 1'b0 : fault_s2[sel[1:0]];
	assign out_item.sample_a = (sel == CH_TELEM) ? sample_a_s2 : '0;
	assign out_item.sample_b = (sel == CH_TELEM) ? sample_b_s2 : '0;
	assign out_item.last     = $onehot(mask_s2);

endmodule

// File: hdl/pspm_checker.sv
// Port-level checks for the pedal sensor plausibility monitor.
// Depends on pspm_pkg; bound to the top level at the end of this file.
module pspm_checker
	import pspm_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_ready,
	input pspm_out_t out_item
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// Within a pass, the next result follows at once on a higher channel.
	a_pass_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_item.last |=>
			out_valid && (out_item.channel > $past(out_item.channel)))
		else $error("pass results out of order or interrupted");

	a_channel_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.channel <= CH_TELEM)
		else $error("result channel out of range");

	a_telem_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.channel == CH_TELEM |-> !out_item.fault)
		else $error("telemetry item carries a fault flag");

	a_check_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.channel != CH_TELEM |->
			out_item.sample_a == '0 && out_item.sample_b == '0)
		else $error("check item carries pedal samples");

endmodule

bind pedal_sensor_plausibility_monitor pspm_checker u_pspm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
